/* src/lsb_pkg.sv */
// Shared types and constants for the link supervisor with retry backoff.
`default_nettype none
package lsb_pkg;

  typedef enum logic [2:0] {
    ST_DISC     = 3'd0,
    ST_CONNING  = 3'd1,
    ST_CONNED   = 3'd2,
    ST_FAILED   = 3'd3,
    ST_FALLBACK = 3'd4
  } state_t;

  localparam logic [2:0] OP_POLL       = 3'd0;
  localparam logic [2:0] OP_CONNECT    = 3'd1;
  localparam logic [2:0] OP_DISCONNECT = 3'd2;
  localparam logic [2:0] OP_FB_START   = 3'd3;
  localparam logic [2:0] OP_FB_STOP    = 3'd4;

  localparam logic [1:0] LS_UP        = 2'd0;
  localparam logic [1:0] LS_REFUSED   = 2'd1;
  localparam logic [1:0] LS_NOT_FOUND = 2'd2;

  localparam logic [1:0] CFG_JOIN_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_LOSS_TOL     = 2'd1;
  localparam logic [1:0] CFG_BASE_BACKOFF = 2'd2;
  localparam logic [1:0] CFG_RETRY_LIMIT  = 2'd3;

  localparam logic [31:0] JOIN_TIMEOUT_RST = 32'd15000;
  localparam logic [31:0] LOSS_TOL_RST     = 32'd3000;
  localparam logic [23:0] BASE_BACKOFF_RST = 24'd30000;
  localparam logic [3:0]  RETRY_LIMIT_RST  = 4'd3;

  typedef struct packed {
    state_t     state;
    logic       loss_pending;
    logic       delay_armed;
    logic       creds_stored;
    logic [3:0] retries;
  } ctl_t;

  typedef struct packed {
    logic [2:0] link_state;
    logic       state_changed;
    logic       issue_join;
    logic       issue_leave;
    logic       issue_fallback;
    logic       announce_name;
    logic       accepted;
    logic [3:0] attempt_number;
  } rslt_t;

endpackage
`default_nettype wire

/* src/link_supervisor_backoff.sv */
// Top level of the link supervisor with exponential retry backoff.
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a poll with link status
//   and the millisecond time, or a connect, disconnect, fallback start or
//   fallback stop request. Each item yields exactly one result item on the
//   output channel (out_valid/out_ready): the new link state, a change flag,
//   command pulses, the accepted flag and the retry count.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
//   taken in one cycle; write them only while no item is in flight.
//   Results are registered. Throughput is one item per cycle while the skid
//   stage is empty; the supervisor state is updated in the accepting cycle,
//   so the next item sees it at once.
//   When the receiver stalls, one more item is held in a skid stage; in_ready
//   drops only while that stage is full.
//   Synchronous reset returns the state to disconnected, clears the retry and
//   debounce state and loads the default register values; in_ready and
//   cfg_ready stay low while reset is asserted.
`default_nettype none
module link_supervisor_backoff #(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [1:0]  in_link_status,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_has_credentials,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_link_state,
  output logic             out_state_changed,
  output logic             out_issue_join,
  output logic             out_issue_leave,
  output logic             out_issue_fallback,
  output logic             out_announce_name,
  output logic             out_accepted,
  output logic [3:0]       out_attempt_number,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [31:0]          join_timeout_r;
  logic [31:0]          loss_tol_r;
  logic [23:0]          base_backoff_r;
  logic [3:0]           retry_limit_r;
  lsb_pkg::ctl_t        ctl_r;
  lsb_pkg::ctl_t        ctl_nxt;
  logic [TIME_BITS-1:0] join_start_r;
  logic [TIME_BITS-1:0] join_start_nxt;
  logic [TIME_BITS-1:0] loss_start_r;
  logic [TIME_BITS-1:0] loss_start_nxt;
  logic [TIME_BITS-1:0] delay_start_r;
  logic [TIME_BITS-1:0] delay_start_nxt;
  logic [TIME_BITS-1:0] pend_delay_r;
  logic [TIME_BITS-1:0] pend_delay_nxt;
  logic [CW-1:0]        now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic                 in_fire;
  lsb_pkg::rslt_t       rslt;
  lsb_pkg::rslt_t       out_data;

  assign cfg_ready = rst_n;
  assign in_fire   = in_valid && in_ready;
  assign now_wide  = CW'(in_now_ms);
  assign now_t     = now_wide[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      join_timeout_r <= lsb_pkg::JOIN_TIMEOUT_RST;
      loss_tol_r     <= lsb_pkg::LOSS_TOL_RST;
      base_backoff_r <= lsb_pkg::BASE_BACKOFF_RST;
      retry_limit_r  <= lsb_pkg::RETRY_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsb_pkg::CFG_JOIN_TIMEOUT: join_timeout_r <= cfg_data;
        lsb_pkg::CFG_LOSS_TOL:     loss_tol_r     <= cfg_data;
        lsb_pkg::CFG_BASE_BACKOFF: base_backoff_r <= cfg_data[23:0];
        lsb_pkg::CFG_RETRY_LIMIT:  retry_limit_r  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r         <= '{state: lsb_pkg::ST_DISC, default: '0};
      join_start_r  <= '0;
      loss_start_r  <= '0;
      delay_start_r <= '0;
      pend_delay_r  <= '0;
    end else if (in_fire) begin
      ctl_r         <= ctl_nxt;
      join_start_r  <= join_start_nxt;
      loss_start_r  <= loss_start_nxt;
      delay_start_r <= delay_start_nxt;
      pend_delay_r  <= pend_delay_nxt;
    end
  end

  lsb_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .op              (in_operation),
    .status          (in_link_status),
    .now             (now_t),
    .creds           (in_has_credentials),
    .ctl             (ctl_r),
    .join_start      (join_start_r),
    .loss_start      (loss_start_r),
    .delay_start     (delay_start_r),
    .pend_delay      (pend_delay_r),
    .join_timeout    (join_timeout_r),
    .loss_tol        (loss_tol_r),
    .base_backoff    (base_backoff_r),
    .retry_limit     (retry_limit_r),
    .ctl_nxt         (ctl_nxt),
    .join_start_nxt  (join_start_nxt),
    .loss_start_nxt  (loss_start_nxt),
    .delay_start_nxt (delay_start_nxt),
    .pend_delay_nxt  (pend_delay_nxt),
    .rslt            (rslt)
  );

  lsb_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (rslt),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_link_state     = out_data.link_state;
  assign out_state_changed  = out_data.state_changed;
  assign out_issue_join     = out_data.issue_join;
  assign out_issue_leave    = out_data.issue_leave;
  assign out_issue_fallback = out_data.issue_fallback;
  assign out_announce_name  = out_data.announce_name;
  assign out_accepted       = out_data.accepted;
  assign out_attempt_number = out_data.attempt_number;

endmodule
`default_nettype wire

/* src/lsb_core.sv */
// Next-state and result logic for one supervisor item.
`default_nettype none
module lsb_core #(
  parameter int TIME_BITS = 32
) (
  input  wire logic [2:0]           op,
  input  wire logic [1:0]           status,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic                 creds,
  input  wire lsb_pkg::ctl_t        ctl,
  input  wire logic [TIME_BITS-1:0] join_start,
  input  wire logic [TIME_BITS-1:0] loss_start,
  input  wire logic [TIME_BITS-1:0] delay_start,
  input  wire logic [TIME_BITS-1:0] pend_delay,
  input  wire logic [31:0]          join_timeout,
  input  wire logic [31:0]          loss_tol,
  input  wire logic [23:0]          base_backoff,
  input  wire logic [3:0]           retry_limit,
  output lsb_pkg::ctl_t             ctl_nxt,
  output logic [TIME_BITS-1:0]      join_start_nxt,
  output logic [TIME_BITS-1:0]      loss_start_nxt,
  output logic [TIME_BITS-1:0]      delay_start_nxt,
  output logic [TIME_BITS-1:0]      pend_delay_nxt,
  output lsb_pkg::rslt_t            rslt
);

  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int DW = (TIME_BITS > 39) ? TIME_BITS : 39;

  logic [TIME_BITS-1:0] join_el;
  logic [TIME_BITS-1:0] loss_el;
  logic [TIME_BITS-1:0] delay_el;
  logic [DW-1:0]        shifted;
  logic [TIME_BITS-1:0] backoff;
  logic                 up;
  logic                 join_late;
  logic                 loss_done;
  logic                 delay_done;
  logic                 retry_spent;
  logic                 join_fail;

  assign join_el     = now - join_start;
  assign loss_el     = now - loss_start;
  assign delay_el    = now - delay_start;
  assign shifted     = DW'(base_backoff) << ctl.retries;
  assign backoff     = (|(shifted >> TIME_BITS)) ? '1 : shifted[TIME_BITS-1:0];
  assign up          = (status == lsb_pkg::LS_UP);
  assign join_late   = CW'(join_el) > CW'(join_timeout);
  assign loss_done   = CW'(loss_el) >= CW'(loss_tol);
  assign delay_done  = delay_el >= pend_delay;
  assign retry_spent = ctl.retries >= retry_limit;
  assign join_fail   = (status == lsb_pkg::LS_REFUSED) ||
                       (status == lsb_pkg::LS_NOT_FOUND) || join_late;

  always_comb begin
    ctl_nxt         = ctl;
    join_start_nxt  = join_start;
    loss_start_nxt  = loss_start;
    delay_start_nxt = delay_start;
    pend_delay_nxt  = pend_delay;
    case (op)
      lsb_pkg::OP_POLL: begin
        case (ctl.state)
          lsb_pkg::ST_CONNING: begin
            if (up) begin
              ctl_nxt.state       = lsb_pkg::ST_CONNED;
              ctl_nxt.retries     = '0;
              ctl_nxt.delay_armed = 1'b0;
            end else if (join_fail) begin
              ctl_nxt.state = lsb_pkg::ST_FAILED;
            end
          end
          lsb_pkg::ST_CONNED: begin
            if (up) begin
              ctl_nxt.loss_pending = 1'b0;
            end else if (!ctl.loss_pending) begin
              ctl_nxt.loss_pending = 1'b1;
              loss_start_nxt       = now;
            end else if (loss_done) begin
              ctl_nxt.state        = lsb_pkg::ST_FAILED;
              ctl_nxt.loss_pending = 1'b0;
            end
          end
          lsb_pkg::ST_DISC: begin
            if (up) begin
              ctl_nxt.state = lsb_pkg::ST_CONNED;
            end
          end
          lsb_pkg::ST_FAILED: begin
            if (up) begin
              ctl_nxt.state       = lsb_pkg::ST_CONNED;
              ctl_nxt.retries     = '0;
              ctl_nxt.delay_armed = 1'b0;
            end else if (retry_spent) begin
              ctl_nxt.retries = '0;
              ctl_nxt.state   = lsb_pkg::ST_FALLBACK;
            end else if (!ctl.delay_armed) begin
              pend_delay_nxt      = backoff;
              delay_start_nxt     = now;
              ctl_nxt.delay_armed = 1'b1;
              ctl_nxt.retries     = ctl.retries + 4'd1;
            end else if (delay_done) begin
              ctl_nxt.delay_armed = 1'b0;
              if (ctl.creds_stored) begin
                join_start_nxt = now;
                ctl_nxt.state  = lsb_pkg::ST_CONNING;
              end
            end
          end
          default: begin
          end
        endcase
      end
      lsb_pkg::OP_CONNECT: begin
        if (creds) begin
          if (ctl.state == lsb_pkg::ST_FALLBACK) begin
            ctl_nxt.retries     = '0;
            ctl_nxt.delay_armed = 1'b0;
          end
          ctl_nxt.creds_stored = 1'b1;
          join_start_nxt       = now;
          ctl_nxt.state        = lsb_pkg::ST_CONNING;
        end
      end
      lsb_pkg::OP_DISCONNECT: begin
        if (ctl.state != lsb_pkg::ST_FALLBACK) begin
          ctl_nxt.state = lsb_pkg::ST_DISC;
        end
      end
      lsb_pkg::OP_FB_START: begin
        ctl_nxt.state = lsb_pkg::ST_FALLBACK;
      end
      lsb_pkg::OP_FB_STOP: begin
        if (ctl.state == lsb_pkg::ST_FALLBACK) begin
          ctl_nxt.retries     = '0;
          ctl_nxt.delay_armed = 1'b0;
          ctl_nxt.state       = lsb_pkg::ST_DISC;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rslt                = '0;
    rslt.accepted       = 1'b1;
    rslt.link_state     = ctl_nxt.state;
    rslt.state_changed  = (ctl_nxt.state != ctl.state);
    rslt.attempt_number = ctl_nxt.retries;
    case (op)
      lsb_pkg::OP_POLL: begin
        case (ctl.state)
          lsb_pkg::ST_CONNING, lsb_pkg::ST_DISC: begin
            rslt.announce_name = up;
          end
          lsb_pkg::ST_FAILED: begin
            if (up) begin
              rslt.announce_name = 1'b1;
            end else if (retry_spent) begin
              rslt.issue_fallback = 1'b1;
              rslt.announce_name  = 1'b1;
            end else if (ctl.delay_armed && delay_done) begin
              rslt.issue_join = ctl.creds_stored;
            end
          end
          default: begin
          end
        endcase
      end
      lsb_pkg::OP_CONNECT: begin
        rslt.accepted   = creds;
        rslt.issue_join = creds;
      end
      lsb_pkg::OP_DISCONNECT: begin
        rslt.accepted    = (ctl.state != lsb_pkg::ST_FALLBACK);
        rslt.issue_leave = (ctl.state != lsb_pkg::ST_FALLBACK);
      end
      lsb_pkg::OP_FB_START: begin
        rslt.issue_fallback = 1'b1;
        rslt.announce_name  = 1'b1;
      end
      lsb_pkg::OP_FB_STOP: begin
      end
      default: begin
        rslt.accepted = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/lsb_outbuf.sv */
// Output register with skid stage for result items.
`default_nettype none
module lsb_outbuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lsb_pkg::rslt_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lsb_pkg::rslt_t      out_data
);

  logic           out_valid_r;
  logic           skid_valid_r;
  lsb_pkg::rslt_t out_data_r;
  lsb_pkg::rslt_t skid_data_r;
  logic           drain;

  assign drain     = !out_valid_r || out_ready;
  assign can_push  = rst_n && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule
`default_nettype wire
